// ----- sv/bcc_pkg.sv -----
// ----------------------------------------------------------------------------
// Button click classifier package
// Shared types and constants: event codes, register indexes, reset values.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned IndexW = 3;
  localparam int unsigned DataW  = 16;

  // Event codes carried in event_kind.
  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_DOUBLE = 2'd1,
    KIND_TRIPLE = 2'd2,
    KIND_LONG   = 2'd3
  } event_kind_t;

  // Configuration register indexes.
  localparam logic [IndexW-1:0] REG_DEBOUNCE = 3'd0;
  localparam logic [IndexW-1:0] REG_SINGLE   = 3'd1;
  localparam logic [IndexW-1:0] REG_DOUBLE   = 3'd2;
  localparam logic [IndexW-1:0] REG_TRIPLE   = 3'd3;
  localparam logic [IndexW-1:0] REG_LONG     = 3'd4;
  localparam logic [IndexW-1:0] REG_BUTTON   = 3'd5;

  // Register values after reset.
  localparam logic [7:0]  RST_DEBOUNCE = 8'd30;
  localparam logic [15:0] RST_SINGLE   = 16'd300;
  localparam logic [15:0] RST_DOUBLE   = 16'd500;
  localparam logic [15:0] RST_TRIPLE   = 16'd700;
  localparam logic [15:0] RST_LONG     = 16'd1500;
  localparam logic [3:0]  RST_BUTTON   = 4'd0;

  // Highest click count that the counter holds.
  localparam logic [1:0] CLICKS_MAX = 2'd3;

  typedef struct packed {
    logic [7:0]  debounce_time;
    logic [15:0] single_window_ms;
    logic [15:0] double_window_ms;
    logic [15:0] triple_window_ms;
    logic [15:0] long_press_ms;
    logic [3:0]  button_id;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    event_kind_t      kind;
    logic [TimeW-1:0] stamp;
    logic [3:0]       button;
  } evt_t;

endpackage

// ----- sv/bcc_in_if.sv -----
// ----------------------------------------------------------------------------
// Sample channel
// Carries one raw pin sample and its millisecond timestamp per transaction.
// ----------------------------------------------------------------------------
interface bcc_in_if;
  logic        valid;
  logic        ready;
  logic        pin_level;
  logic [31:0] now_ms;

  modport source (output valid, output pin_level, output now_ms, input ready);
  modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

// ----- sv/bcc_out_if.sv -----
// ----------------------------------------------------------------------------
// Event channel
// Carries one classified button event per transaction.
// ----------------------------------------------------------------------------
interface bcc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [31:0] event_time;
  logic [3:0]  event_button;

  modport source (output valid, output event_kind, output event_time,
                  output event_button, input ready);
  modport sink   (input valid, input event_kind, input event_time,
                  input event_button, output ready);
endinterface

// ----- sv/bcc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and write data per transaction.
// ----------------------------------------------------------------------------
interface bcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/bcc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the timing windows and button identifier; ignores unknown indexes.
// ----------------------------------------------------------------------------
module bcc_cfg_regs
  import bcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [IndexW-1:0] wr_index,
  input  logic [DataW-1:0]  wr_data,
  output cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time    <= RST_DEBOUNCE;
      cfg.single_window_ms <= RST_SINGLE;
      cfg.double_window_ms <= RST_DOUBLE;
      cfg.triple_window_ms <= RST_TRIPLE;
      cfg.long_press_ms    <= RST_LONG;
      cfg.button_id        <= RST_BUTTON;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEBOUNCE: cfg.debounce_time    <= wr_data[7:0];
        REG_SINGLE:   cfg.single_window_ms <= wr_data;
        REG_DOUBLE:   cfg.double_window_ms <= wr_data;
        REG_TRIPLE:   cfg.triple_window_ms <= wr_data;
        REG_LONG:     cfg.long_press_ms    <= wr_data;
        REG_BUTTON:   cfg.button_id        <= wr_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/bcc_core.sv -----
// ----------------------------------------------------------------------------
// Classifier core
// Debounce and click state with the next-state logic for one sample.
// ----------------------------------------------------------------------------
module bcc_core
  import bcc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             pin_level,
  input  logic [TimeW-1:0] now_ms,
  input  cfg_t             cfg,
  output evt_t             evt
);

  logic             prev_raw, prev_raw_next;
  logic             stable_level, stable_level_next;
  logic [TimeW-1:0] bounce_start, bounce_start_next;
  logic [TimeW-1:0] edge_time, edge_time_next;
  logic [TimeW-1:0] first_click_at, first_click_at_next;
  logic [1:0]       clicks, clicks_next;
  logic             long_sent, long_sent_next;

  logic [TimeW-1:0] settle_age;
  logic [TimeW-1:0] idle;
  logic [TimeW-1:0] total;
  logic [15:0]      gap;

  always_comb begin
    prev_raw_next       = pin_level;
    stable_level_next   = stable_level;
    bounce_start_next   = (pin_level != prev_raw) ? now_ms : bounce_start;
    edge_time_next      = edge_time;
    first_click_at_next = first_click_at;
    clicks_next         = clicks;
    long_sent_next      = long_sent;
    evt.valid           = 1'b0;
    evt.kind            = KIND_SINGLE;
    evt.stamp           = now_ms;
    evt.button          = cfg.button_id;

    settle_age = now_ms - bounce_start_next;

    // A level that differs from the debounced one counts once it has settled.
    if (settle_age > {24'd0, cfg.debounce_time} && pin_level != stable_level) begin
      if (!pin_level) begin
        if (clicks == 2'd0) begin
          first_click_at_next = now_ms;
        end
        if (clicks != CLICKS_MAX) begin
          clicks_next = clicks + 2'd1;
        end
        long_sent_next = 1'b0;
      end else if (long_sent) begin
        clicks_next = 2'd0;
      end
      edge_time_next    = now_ms;
      stable_level_next = pin_level;
    end

    idle  = now_ms - edge_time_next;
    total = now_ms - first_click_at_next;
    gap   = (cfg.double_window_ms > cfg.single_window_ms)
          ? cfg.double_window_ms - cfg.single_window_ms : 16'd0;

    if (!stable_level_next) begin
      // Held: report a long press once.
      if (!long_sent_next && idle > {16'd0, cfg.long_press_ms}) begin
        long_sent_next = 1'b1;
        evt.valid      = 1'b1;
        evt.kind       = KIND_LONG;
      end
    end else if (clicks_next == 2'd3) begin
      clicks_next = 2'd0;
      evt.valid   = 1'b1;
      evt.kind    = KIND_TRIPLE;
    end else if (clicks_next == 2'd2 &&
                 (total > {16'd0, cfg.triple_window_ms} || idle > {16'd0, gap})) begin
      clicks_next = 2'd0;
      evt.valid   = 1'b1;
      evt.kind    = KIND_DOUBLE;
    end else if (clicks_next == 2'd1 &&
                 (total > {16'd0, cfg.double_window_ms} ||
                  idle > {16'd0, cfg.single_window_ms})) begin
      clicks_next = 2'd0;
      evt.valid   = 1'b1;
      evt.kind    = KIND_SINGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_raw       <= 1'b1;
      stable_level   <= 1'b1;
      bounce_start   <= '0;
      edge_time      <= '0;
      first_click_at <= '0;
      clicks         <= 2'd0;
      long_sent      <= 1'b0;
    end else if (step) begin
      prev_raw       <= prev_raw_next;
      stable_level   <= stable_level_next;
      bounce_start   <= bounce_start_next;
      edge_time      <= edge_time_next;
      first_click_at <= first_click_at_next;
      clicks         <= clicks_next;
      long_sent      <= long_sent_next;
    end
  end

endmodule

// ----- sv/button_click_classifier.sv -----
// ----------------------------------------------------------------------------
// Button click classifier
// Debounces an active-low button and reports single, double, triple clicks
// and long presses.
// ----------------------------------------------------------------------------
// Usage:
// Each sample transaction brings one raw pin level (0 pressed) and a free
// running millisecond timestamp that wraps modulo 2^32. Every sample is
// classified; most produce no event, some produce exactly one event
// transaction carrying its kind, the sample's timestamp and the button id.
// The configuration channel writes the debounce time, the three click
// windows, the long-press time and the button id; writes to unknown indexes
// are dropped. The configuration channel is always ready, and it should only
// be written while no sample is in flight.
// Throughput is one sample per clock while the event receiver does not stall.
// A sample is captured in an input register at its transaction and
// classified from there once the output register can take a result; its
// event, if any, is registered in the output register. The combinational
// logic between those registers holds the whole decision: a few 32-bit
// modular subtractions and compares.
// Reset restores the default windows and returns the button to released
// with no clicks pending. When the event receiver stalls, the output
// register holds its event and the input register fills, after which the
// sample channel drops ready until the event is taken.
// ----------------------------------------------------------------------------
module button_click_classifier
  import bcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  bcc_in_if.sink     sample,
  bcc_out_if.source  result,
  bcc_cfg_if.sink    cfg
);

  cfg_t cfg_q;
  evt_t evt;

  // Input register.
  logic             in_valid;
  logic             in_pin;
  logic [TimeW-1:0] in_now;

  // Output register.
  logic             out_valid;
  evt_t             out_evt;

  logic advance;
  logic step;

  // The output register can take a new result when empty or being drained.
  assign advance      = !out_valid || result.ready;
  assign step         = in_valid && advance;
  assign sample.ready = !in_valid || advance;
  assign cfg.ready    = 1'b1;

  bcc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_q)
  );

  bcc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .pin_level (in_pin),
    .now_ms    (in_now),
    .cfg       (cfg_q),
    .evt       (evt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_pin <= sample.pin_level;
      in_now <= sample.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && evt.valid && advance) begin
      out_evt <= evt;
    end
  end

  assign result.valid        = out_valid;
  assign result.event_kind   = out_evt.kind;
  assign result.event_time   = out_evt.stamp;
  assign result.event_button = out_evt.button;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click classifier testbench
// Drives debounced and bouncing button gestures with millisecond timestamps,
// predicts single, double, triple and long-press events in a local copy of
// the classifier state, and compares every event transaction in order.
// ----------------------------------------------------------------------------
module tb_top
  import bcc_pkg::*;
();

  // The run is ended as a hang well beyond the slowest legal run.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Cycles allowed for a sample to leave the pipeline when it raises no event.
  localparam int unsigned DRAIN_CYCLES = 8;

  // Indexes that decode to no register; writes to them must be dropped.
  localparam logic [IndexW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IndexW-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    event_kind_t kind;
    logic [31:0] stamp;
    logic [3:0]  button;
  } click_event_t;

  logic clk = 1'b0;
  logic rst;

  bcc_in_if  sample_ch ();
  bcc_out_if event_ch ();
  bcc_cfg_if cfg_ch ();

  button_click_classifier uut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (event_ch),
    .cfg    (cfg_ch)
  );

  always #2 clk = ~clk;

  // Events that the classifier still owes us, oldest first.
  click_event_t expected_events[$];
  click_event_t head_event;
  int unsigned  errors = 0;
  int unsigned  samples_sent = 0;
  int unsigned  cycle_count = 0;

  // Idling controls: percent chance of a sender gap before a sample and of a
  // receiver stall burst on any cycle. Both are reshuffled while idling is on.
  int unsigned gap_pct = 25;
  int unsigned stall_pct = 25;
  bit          idling_enabled = 1'b1;
  int unsigned stall_left = 0;

  // Timestamp of the most recent sample; it wraps like the real millisecond tick.
  logic [31:0] clock_ms = 32'd0;

  // Local copy of the configuration registers.
  logic [7:0]  cfg_debounce = RST_DEBOUNCE;
  logic [15:0] cfg_single   = RST_SINGLE;
  logic [15:0] cfg_double   = RST_DOUBLE;
  logic [15:0] cfg_triple   = RST_TRIPLE;
  logic [15:0] cfg_long     = RST_LONG;
  logic [3:0]  cfg_button   = RST_BUTTON;

  // Local copy of the classifier state, at its reset values.
  logic        last_pin    = 1'b1;
  logic        debounced   = 1'b1;
  logic [31:0] bounce_at   = 32'd0;
  logic [31:0] edge_at     = 32'd0;
  logic [31:0] first_click = 32'd0;
  logic [1:0]  clicks      = 2'd0;
  logic        long_done   = 1'b0;

  // The idle gap allowed between the two clicks of a double. It clamps at
  // zero when the double window is not wider than the single window.
  function automatic logic [31:0] double_gap();
    double_gap = (cfg_double > cfg_single) ? {16'd0, cfg_double - cfg_single} : 32'd0;
  endfunction

  // Advances the local classifier by one accepted sample and queues the event
  // that it raises, if any. All time differences wrap modulo 2^32.
  function automatic void classify_sample(input logic pin, input logic [31:0] t);
    logic [31:0]  settled;
    logic [31:0]  idle;
    logic [31:0]  total;
    click_event_t ev;
    logic         fire;
    fire      = 1'b0;
    ev.kind   = KIND_SINGLE;
    ev.stamp  = t;
    ev.button = cfg_button;

    // Any raw change restarts the debounce timer.
    if (pin != last_pin) begin
      bounce_at = t;
    end
    last_pin = pin;

    // A level held for longer than the debounce time becomes an edge.
    settled = t - bounce_at;
    if (settled > {24'd0, cfg_debounce} && pin != debounced) begin
      if (!pin) begin
        if (clicks == 2'd0) begin
          first_click = t;
        end
        if (clicks < CLICKS_MAX) begin
          clicks = clicks + 2'd1;
        end
        long_done = 1'b0;
      end else if (long_done) begin
        // A release after a reported long press forgets that press.
        clicks = 2'd0;
      end
      edge_at   = t;
      debounced = pin;
    end

    idle  = t - edge_at;
    total = t - first_click;

    // Long press is judged only while held and click decisions only while
    // released, so a sample raises at most one event.
    if (!debounced && !long_done) begin
      if (idle > {16'd0, cfg_long}) begin
        long_done = 1'b1;
        fire      = 1'b1;
        ev.kind   = KIND_LONG;
      end
    end else if (debounced && clicks != 2'd0) begin
      if (clicks == CLICKS_MAX) begin
        fire    = 1'b1;
        ev.kind = KIND_TRIPLE;
      end else if (clicks == 2'd2 &&
                   (total > {16'd0, cfg_triple} || idle > double_gap())) begin
        fire    = 1'b1;
        ev.kind = KIND_DOUBLE;
      end else if (clicks == 2'd1 &&
                   (total > {16'd0, cfg_double} || idle > {16'd0, cfg_single})) begin
        fire    = 1'b1;
        ev.kind = KIND_SINGLE;
      end
      if (fire) begin
        clicks = 2'd0;
      end
    end

    if (fire) begin
      expected_events.push_back(ev);
    end
  endfunction

  // Sends one sample, after an optional gap burst, and waits for acceptance.
  // Valid is left high so that back-to-back samples need no second assignment.
  task automatic send_sample(input logic pin, input logic [31:0] t);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.pin_level <= pin;
    sample_ch.now_ms    <= t;
    do @(posedge clk); while (!sample_ch.ready);
    classify_sample(pin, t);
    samples_sent++;
  endtask

  // Moves the millisecond clock forward by dt and samples the pin there.
  task automatic advance(input logic pin, input logic [31:0] dt);
    clock_ms = clock_ms + dt;
    send_sample(pin, clock_ms);
  endtask

  // Holds the sender until every owed event has arrived and the pipeline has
  // emptied. Registers are only written after this.
  task automatic settle_idle();
    sample_ch.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write transaction. Valid stays high for a following write.
  task automatic write_reg(input logic [IndexW-1:0] index, input logic [DataW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (index)
      REG_DEBOUNCE: cfg_debounce = data[7:0];
      REG_SINGLE:   cfg_single   = data;
      REG_DOUBLE:   cfg_double   = data;
      REG_TRIPLE:   cfg_triple   = data;
      REG_LONG:     cfg_long     = data;
      REG_BUTTON:   cfg_button   = data[3:0];
      default: ;
    endcase
  endtask

  // Writes every register in index order. Debounce and button values may
  // carry high bits that the block has to mask off.
  task automatic apply_settings(input logic [15:0] deb, input logic [15:0] sgl,
                                input logic [15:0] dbl, input logic [15:0] tpl,
                                input logic [15:0] lng, input logic [15:0] btn);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_SINGLE, sgl);
    write_reg(REG_DOUBLE, dbl);
    write_reg(REG_TRIPLE, tpl);
    write_reg(REG_LONG, lng);
    write_reg(REG_BUTTON, btn);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic apply_random_settings();
    apply_settings(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 1200)),
                   16'($urandom_range(0, 1200)), 16'($urandom_range(0, 1500)),
                   16'($urandom_range(0, 3000)), 16'($urandom_range(0, 16'hFFFF)));
  endtask

  // A span that lands on, just beside, or somewhere around a time limit, so
  // the strict greater-than compares are hit from both sides.
  function automatic logic [31:0] near_mark(input logic [31:0] mark);
    case ($urandom_range(0, 4))
      0: near_mark = mark;
      1: near_mark = mark + 32'd1;
      2: near_mark = (mark == 32'd0) ? 32'd0 : mark - 32'd1;
      default: near_mark = $urandom_range(0, mark + mark / 2 + 2);
    endcase
  endfunction

  function automatic logic [31:0] hold_span();
    case ($urandom_range(0, 4))
      0: hold_span = $urandom_range(0, cfg_debounce + 40);
      1: hold_span = $urandom_range(0, cfg_long);
      2, 3: hold_span = near_mark({16'd0, cfg_long});
      default: hold_span = cfg_long + $urandom_range(1, 300);
    endcase
  endfunction

  // Contact bounce: a few short toggles, ending on the target level.
  task automatic bounce_to(input logic level);
    int unsigned n;
    n = $urandom_range(0, 2);
    repeat (n) begin
      advance(level, $urandom_range(1, cfg_debounce / 2 + 1));
      advance(~level, $urandom_range(1, cfg_debounce / 2 + 1));
    end
    advance(level, $urandom_range(1, cfg_debounce / 2 + 1));
  endtask

  // Usually waits out the debounce time; now and then falls short of it.
  task automatic settle_level(input logic level);
    if ($urandom_range(0, 5) == 0) begin
      advance(level, $urandom_range(0, cfg_debounce));
    end else begin
      advance(level, cfg_debounce + 1 + $urandom_range(0, 2));
    end
  endtask

  // One random gesture. Most are clean presses with random hold and idle
  // times; the rest are pin noise and wild timestamp jumps.
  task automatic random_gesture();
    int unsigned pick;
    int unsigned n;
    logic [31:0] mark;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) advance($urandom_range(0, 1) != 0, $urandom_range(0, 2 * cfg_debounce + 2));
    end else if (pick == 1) begin
      advance($urandom_range(0, 1) != 0, $urandom());
    end else begin
      bounce_to(1'b0);
      settle_level(1'b0);
      n = $urandom_range(0, 2);
      repeat (n) advance(1'b0, hold_span());
      bounce_to(1'b1);
      settle_level(1'b1);
      // No idle sample at all lets the next press chain into a multi-click.
      n = $urandom_range(0, 2);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: mark = {16'd0, cfg_single};
          1: mark = double_gap();
          2: mark = {16'd0, cfg_double};
          default: mark = {16'd0, cfg_triple};
        endcase
        advance(1'b1, near_mark(mark));
      end
    end
  endtask

  task automatic run_gestures(input int unsigned budget);
    int unsigned target;
    target = samples_sent + budget;
    while (samples_sent < target) begin
      if (idling_enabled && $urandom_range(0, 7) == 0) begin
        gap_pct   = 15 * $urandom_range(0, 2);
        stall_pct = 15 * $urandom_range(0, 2);
      end
      random_gesture();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests, run at the reset settings.
  // ---------------------------------------------------------------------------

  // One click that closes on the single window. The press lands on the
  // largest timestamp, so the debounce and window math cross the wrap.
  task automatic test_single_click();
    clock_ms = 32'hFFFF_FFFA;
    advance(1'b0, 32'd5);
    advance(1'b0, 32'd31);
    advance(1'b1, 32'd10);
    advance(1'b1, 32'd31);
    advance(1'b1, 32'd301);
  endtask

  // Two clicks that close on the double idle gap.
  task automatic test_double_click();
    repeat (2) begin
      advance(1'b0, 32'd10);
      advance(1'b0, 32'd31);
      advance(1'b1, 32'd10);
      advance(1'b1, 32'd31);
    end
    advance(1'b1, 32'd201);
  endtask

  // The third release reports a triple at once, with no idle sample.
  task automatic test_triple_click();
    repeat (3) begin
      advance(1'b0, 32'd10);
      advance(1'b0, 32'd31);
      advance(1'b1, 32'd10);
      advance(1'b1, 32'd31);
    end
  endtask

  // Holding exactly the long-press time does nothing; one more millisecond
  // reports it. The release after it drops the pending click.
  task automatic test_long_press();
    advance(1'b0, 32'd10);
    advance(1'b0, 32'd31);
    advance(1'b0, 32'd1500);
    advance(1'b0, 32'd1);
    advance(1'b1, 32'd10);
    advance(1'b1, 32'd31);
  endtask

  // ---------------------------------------------------------------------------
  // Random tests, each under register settings that it writes.
  // ---------------------------------------------------------------------------

  task automatic test_default_settings();
    settle_idle();
    apply_settings(16'd30, 16'd300, 16'd500, 16'd700, 16'd1500, 16'd9);
    run_gestures(130);
  endtask

  // Every time limit at zero: a press reports long at its first held sample past its edge time.
  task automatic test_zero_windows();
    settle_idle();
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_gestures(90);
  endtask

  // All data bits set: debounce and button keep only their low bits.
  task automatic test_max_windows();
    settle_idle();
    clock_ms = $urandom();
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_gestures(90);
  endtask

  // Double window narrower than the single window, so the double idle gap
  // clamps at zero.
  task automatic test_gap_clamp();
    settle_idle();
    apply_settings(16'($urandom_range(0, 60)), 16'd600, 16'd400, 16'd900, 16'd2000,
                   16'($urandom_range(0, 15)));
    run_gestures(110);
  endtask

  // Writes to undecoded indexes must leave every register alone.
  task automatic test_ignored_writes();
    settle_idle();
    write_reg(REG_SPARE_LO, 16'($urandom_range(0, 16'hFFFF)));
    write_reg(REG_SPARE_HI, 16'($urandom_range(0, 16'hFFFF)));
    cfg_ch.valid <= 1'b0;
    run_gestures(50);
    settle_idle();
    write_reg(REG_SPARE_HI, 16'd0);
    apply_random_settings();
    run_gestures(60);
  endtask

  task automatic test_random_settings();
    repeat (2) begin
      settle_idle();
      clock_ms = $urandom();
      apply_random_settings();
      run_gestures(110);
    end
  endtask

  // Full rate on both sides to close the run.
  task automatic test_no_idling();
    idling_enabled = 1'b0;
    gap_pct        = 0;
    stall_pct      = 0;
    settle_idle();
    apply_random_settings();
    run_gestures(100);
  endtask

  // ---------------------------------------------------------------------------
  // Event receiver: random stall bursts, and an in-order check of every event
  // transaction against the oldest owed event.
  // ---------------------------------------------------------------------------
  initial begin
    event_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && event_ch.valid && event_ch.ready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event, expected none, got kind %0d time %h button %0d",
                   $time, event_ch.event_kind, event_ch.event_time, event_ch.event_button);
          errors++;
        end else begin
          head_event = expected_events.pop_front();
          if (event_ch.event_kind != head_event.kind) begin
            $display("%0t: event_kind expected %0d, actual %0d",
                     $time, head_event.kind, event_ch.event_kind);
            errors++;
          end
          if (event_ch.event_time != head_event.stamp) begin
            $display("%0t: event_time expected %h, actual %h",
                     $time, head_event.stamp, event_ch.event_time);
            errors++;
          end
          if (event_ch.event_button != head_event.button) begin
            $display("%0t: event_button expected %0d, actual %0d",
                     $time, head_event.button, event_ch.event_button);
            errors++;
          end
        end
      end
      // A stall burst holds ready low until its random length has run out.
      if (stall_left != 0) begin
        stall_left--;
        event_ch.ready <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 6);
        event_ch.ready <= 1'b0;
      end else begin
        event_ch.ready <= 1'b1;
      end
    end
  end

  // Hang guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst                 = 1'b1;
    sample_ch.valid     = 1'b0;
    sample_ch.pin_level = 1'b1;
    sample_ch.now_ms    = 32'd0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_DEBOUNCE;
    cfg_ch.data         = 16'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_single_click();
    test_double_click();
    test_triple_click();
    test_long_press();
    test_default_settings();
    test_zero_windows();
    test_max_windows();
    test_gap_clamp();
    test_ignored_writes();
    test_random_settings();
    test_no_idling();

    // Every owed event in, then a drain wait to catch stray ones.
    settle_idle();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/bcc_pkg.sv
sv/bcc_in_if.sv
sv/bcc_out_if.sv
sv/bcc_cfg_if.sv
sv/bcc_cfg_regs.sv
sv/bcc_core.sv
sv/button_click_classifier.sv
test/tb_top.sv
